>>> src/solev_pkg.sv
// Shared types and constants for the clipped-square output layer evaluator.
// Holds the store geometry, word codes, register indexes, reset values,
// the controller state type and the controller/datapath command and status structs.
package solev_pkg;

    // Weight store geometry: eight bucket rows of 2048 words each.
    localparam int STORE_BUCKETS = 8;
    localparam int ROW_WORDS     = 2048;
    localparam int ROW_AW        = 11;
    localparam int BUCKET_W      = 3;
    localparam int STORE_DEPTH   = STORE_BUCKETS * ROW_WORDS;

    // Piece counts are 6 bits wide; buckets span the 32 pieces of a full board.
    localparam int PC_W       = 6;
    localparam int PIECE_SPAN = 32;
    localparam int MIN_PIECES = 2;

    localparam int WORD_W = 16;
    localparam int SUM_W  = 32;
    localparam int SQ_W   = 30;
    localparam int CLIP_W = 15;
    localparam int ESC_W  = 12;
    localparam int E2_W   = 33;

    // Shared divider: magnitudes up to 44 bits by divisors up to 30 bits.
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 30;

    localparam logic [ROW_AW-1:0] CNT_MAX = '1;

    // Word codes carried in the mode field.
    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_EVAL   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACT_CLIP     = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_SCALE = 2'd1;
    localparam logic [1:0] CFG_EVAL_SCALE   = 2'd2;
    localparam logic [1:0] CFG_EVAL_LIMIT   = 2'd3;

    localparam logic [CLIP_W-1:0] RST_ACT_CLIP     = 15'd255;
    localparam logic [CLIP_W-1:0] RST_WEIGHT_SCALE = 15'd64;
    localparam logic [ESC_W-1:0]  RST_EVAL_SCALE   = 12'd400;
    localparam logic [CLIP_W-1:0] RST_EVAL_LIMIT   = 15'd31900;

    // Divider operand select.
    localparam logic DIV_SEL_SUM    = 1'b0;
    localparam logic DIV_SEL_SCALED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_ACC,
        ST_DIV1,
        ST_WAIT1,
        ST_BIAS,
        ST_SCALE,
        ST_DIV2,
        ST_WAIT2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic wr_weight;
        logic wr_bias;
        logic take_eval;
        logic prod;
        logic acc;
        logic div_start;
        logic div_sel;
        logic clear_sum;
        logic bias_add;
        logic scale;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_done;
    } status_t;

endpackage

>>> src/solev_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Standalone; no package dependency.
module solev_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> src/solev_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Divisor is positive. No package dependency.
module solev_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 30
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W:0]   num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [NUM_W:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W:0]   num_abs;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_abs  = num[NUM_W] ? (-num) : num;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quo  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num_abs[NUM_W-1:0];
            den_reg <= den;
            neg_reg <= num[NUM_W];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

endmodule

>>> src/solev_dp.sv
// Datapath of the output layer evaluator: configuration registers, weight
// and bias stores, squaring, products, running sum, final scaling and clamp.
// Depends on solev_pkg, solev_ram and solev_div.
module solev_dp #(
    parameter int HIDDEN_SIZE = 1024,
    parameter int BUCKETS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [14:0]           cfg_data,
    input  logic [2:0]            table_bucket,
    input  logic [10:0]           table_index,
    input  logic signed [15:0]    table_value,
    input  logic [5:0]            piece_count,
    input  logic                  white_to_move,
    input  logic signed [15:0]    white_value,
    input  logic signed [15:0]    black_value,
    input  logic                  last_element,
    input  solev_pkg::cmd_t       cmd,
    output solev_pkg::status_t    status,
    output logic signed [15:0]    evaluation,
    output logic [2:0]            used_bucket
);

    localparam int BucketDiv  = (solev_pkg::PIECE_SPAN + BUCKETS - 1) / BUCKETS;
    localparam int BucketMax  = (BUCKETS < solev_pkg::STORE_BUCKETS) ?
                                (BUCKETS - 1) : (solev_pkg::STORE_BUCKETS - 1);
    localparam int PcEntries  = 2 ** solev_pkg::PC_W;
    localparam logic [solev_pkg::ROW_AW-1:0] HidOfs =
        solev_pkg::ROW_AW'(HIDDEN_SIZE % solev_pkg::ROW_WORDS);
    localparam int AW = $clog2(solev_pkg::STORE_DEPTH);

    // Configuration registers.
    logic [14:0] act_clip_reg;
    logic [14:0] weight_scale_reg;
    logic [11:0] eval_scale_reg;
    logic [14:0] eval_limit_reg;

    // Element state.
    logic [31:0] sum_reg;
    logic [10:0] counter_reg;

    // Per-element pipeline registers.
    logic [2:0]  bucket_reg;
    logic        last_reg;
    logic        active_reg;
    logic [29:0] sq_stm_reg;
    logic [29:0] sq_nstm_reg;
    logic [31:0] p_stm_reg;
    logic [31:0] p_nstm_reg;

    // Final-stage registers.
    logic signed [32:0] e2_reg;
    logic signed [44:0] e3_reg;
    logic [29:0]        qq_reg;
    logic signed [15:0] evaluation_reg;
    logic [2:0]         used_bucket_reg;

    logic [15:0] bias_mem [solev_pkg::STORE_BUCKETS];

    logic [2:0]  bucket_lut [PcEntries];
    logic [2:0]  bucket_now;
    logic [14:0] qa;
    logic [14:0] qb;
    logic [14:0] c_stm;
    logic [14:0] c_nstm;
    logic signed [15:0] v_stm;
    logic signed [15:0] v_nstm;
    logic [15:0] w_stm;
    logic [15:0] w_nstm;
    logic signed [46:0] prod_stm;
    logic signed [46:0] prod_nstm;
    logic signed [45:0] scaled;
    logic signed [44:0] div_num;
    logic [29:0]        div_den;
    logic signed [44:0] div_quo;
    logic               div_done;
    logic signed [44:0] lim_pos;
    logic signed [44:0] lim_neg;
    logic signed [44:0] clamped;
    logic [10:0]        addr_other;

    // Bucket table indexed by the raw piece count; counts below two act as two.
    for (genvar g = 0; g < PcEntries; g++)
    begin : g_bucket
        localparam int Raw = (g < solev_pkg::MIN_PIECES) ? 0 :
                             (g - solev_pkg::MIN_PIECES) / BucketDiv;
        localparam int Sat = (Raw > BucketMax) ? BucketMax : Raw;
        assign bucket_lut[g] = 3'(Sat);
    end

    function automatic logic [14:0] clip(input logic signed [15:0] v,
                                         input logic [14:0] top_val);
        logic [14:0] r;
        if (v[15])
        begin
            r = '0;
        end
        else if (v[14:0] > top_val)
        begin
            r = top_val;
        end
        else
        begin
            r = v[14:0];
        end
        return r;
    endfunction

    always_comb
    begin
        bucket_now = bucket_lut[piece_count];
        qa         = (act_clip_reg == '0) ? 15'd1 : act_clip_reg;
        qb         = (weight_scale_reg == '0) ? 15'd1 : weight_scale_reg;
        v_stm      = white_to_move ? white_value : black_value;
        v_nstm     = white_to_move ? black_value : white_value;
        c_stm      = clip(v_stm, act_clip_reg);
        c_nstm     = clip(v_nstm, act_clip_reg);
        addr_other = counter_reg + HidOfs;
        prod_stm   = $signed({1'b0, sq_stm_reg}) * $signed(w_stm);
        prod_nstm  = $signed({1'b0, sq_nstm_reg}) * $signed(w_nstm);
        scaled     = e2_reg * $signed({1'b0, eval_scale_reg});
        div_num    = (cmd.div_sel == solev_pkg::DIV_SEL_SCALED) ?
                     e3_reg : {{13{sum_reg[31]}}, sum_reg};
        div_den    = (cmd.div_sel == solev_pkg::DIV_SEL_SCALED) ?
                     qq_reg : {15'd0, qa};
        lim_pos    = $signed({30'd0, eval_limit_reg});
        lim_neg    = -lim_pos;
        if (div_quo > lim_pos)
        begin
            clamped = lim_pos;
        end
        else if (div_quo < lim_neg)
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = div_quo;
        end
    end

    solev_ram #(
        .WIDTH (solev_pkg::WORD_W),
        .DEPTH (solev_pkg::STORE_DEPTH)
    ) u_weights (
        .clk       (clk),
        .wr_en     (cmd.wr_weight),
        .wr_addr   (AW'({table_bucket, table_index})),
        .wr_data   (table_value),
        .rd_en     (cmd.take_eval),
        .rd_addr_a (AW'({bucket_now, counter_reg})),
        .rd_addr_b (AW'({bucket_now, addr_other})),
        .rd_data_a (w_stm),
        .rd_data_b (w_nstm)
    );

    solev_div #(
        .NUM_W (solev_pkg::DIV_NUM_W),
        .DEN_W (solev_pkg::DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Configuration and running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_clip_reg     <= solev_pkg::RST_ACT_CLIP;
            weight_scale_reg <= solev_pkg::RST_WEIGHT_SCALE;
            eval_scale_reg   <= solev_pkg::RST_EVAL_SCALE;
            eval_limit_reg   <= solev_pkg::RST_EVAL_LIMIT;
            sum_reg          <= '0;
            counter_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    solev_pkg::CFG_ACT_CLIP:     act_clip_reg     <= cfg_data;
                    solev_pkg::CFG_WEIGHT_SCALE: weight_scale_reg <= cfg_data;
                    solev_pkg::CFG_EVAL_SCALE:   eval_scale_reg   <= cfg_data[11:0];
                    solev_pkg::CFG_EVAL_LIMIT:   eval_limit_reg   <= cfg_data;
                    default:                     ;
                endcase
            end
            if (cmd.clear_sum)
            begin
                sum_reg     <= '0;
                counter_reg <= '0;
            end
            else
            begin
                if (cmd.take_eval && (counter_reg != solev_pkg::CNT_MAX))
                begin
                    counter_reg <= counter_reg + 11'd1;
                end
                if (cmd.acc && active_reg)
                begin
                    sum_reg <= sum_reg + p_stm_reg + p_nstm_reg;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_bias)
        begin
            bias_mem[table_bucket] <= table_value;
        end
        if (cmd.take_eval)
        begin
            bucket_reg  <= bucket_now;
            last_reg    <= last_element;
            active_reg  <= (int'(counter_reg) < HIDDEN_SIZE);
            sq_stm_reg  <= 30'(c_stm) * 30'(c_stm);
            sq_nstm_reg <= 30'(c_nstm) * 30'(c_nstm);
        end
        if (cmd.prod)
        begin
            p_stm_reg  <= prod_stm[31:0];
            p_nstm_reg <= prod_nstm[31:0];
        end
        if (cmd.bias_add)
        begin
            e2_reg <= div_quo[32:0] + {{17{bias_mem[bucket_reg][15]}}, bias_mem[bucket_reg]};
            qq_reg <= 30'(qa) * 30'(qb);
        end
        if (cmd.scale)
        begin
            e3_reg <= scaled[44:0];
        end
        if (cmd.out_load)
        begin
            evaluation_reg  <= clamped[15:0];
            used_bucket_reg <= bucket_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.div_done = div_done;
    assign evaluation      = evaluation_reg;
    assign used_bucket     = used_bucket_reg;

endmodule

>>> src/solev_ctrl.sv
// Controller of the output layer evaluator: sequences element accumulation,
// the two serial divisions and the result register. Depends on solev_pkg.
module solev_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           mode,
    input  logic                 result_ready,
    input  solev_pkg::status_t   status,
    output logic                 item_ready,
    output logic                 result_valid,
    output solev_pkg::cmd_t      cmd
);

    solev_pkg::state_t state_reg;
    solev_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            solev_pkg::ST_IDLE:
            begin
                if (item_valid && (mode == solev_pkg::MODE_EVAL))
                begin
                    state_next = solev_pkg::ST_PROD;
                end
            end
            solev_pkg::ST_PROD:  state_next = solev_pkg::ST_ACC;
            solev_pkg::ST_ACC:
            begin
                state_next = status.last ? solev_pkg::ST_DIV1 : solev_pkg::ST_IDLE;
            end
            solev_pkg::ST_DIV1:  state_next = solev_pkg::ST_WAIT1;
            solev_pkg::ST_WAIT1:
            begin
                if (status.div_done)
                begin
                    state_next = solev_pkg::ST_BIAS;
                end
            end
            solev_pkg::ST_BIAS:  state_next = solev_pkg::ST_SCALE;
            solev_pkg::ST_SCALE: state_next = solev_pkg::ST_DIV2;
            solev_pkg::ST_DIV2:  state_next = solev_pkg::ST_WAIT2;
            solev_pkg::ST_WAIT2:
            begin
                if (status.div_done)
                begin
                    state_next = solev_pkg::ST_OUT;
                end
            end
            solev_pkg::ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = solev_pkg::ST_IDLE;
                end
            end
            default:             state_next = solev_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            solev_pkg::ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.wr_weight = item_valid && (mode == solev_pkg::MODE_WEIGHT);
                cmd.wr_bias   = item_valid && (mode == solev_pkg::MODE_BIAS);
                cmd.take_eval = item_valid && (mode == solev_pkg::MODE_EVAL);
            end
            solev_pkg::ST_PROD:  cmd.prod = 1'b1;
            solev_pkg::ST_ACC:   cmd.acc  = 1'b1;
            solev_pkg::ST_DIV1:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = solev_pkg::DIV_SEL_SUM;
                cmd.clear_sum = 1'b1;
            end
            solev_pkg::ST_BIAS:  cmd.bias_add = 1'b1;
            solev_pkg::ST_SCALE: cmd.scale    = 1'b1;
            solev_pkg::ST_DIV2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = solev_pkg::DIV_SEL_SCALED;
            end
            solev_pkg::ST_OUT:   cmd.out_load = !out_valid_reg || result_ready;
            default:             ;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= solev_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

>>> src/screlu_output_layer_eval.sv
// Top level of the clipped-square output layer evaluator.
// Depends on solev_pkg, solev_ctrl and solev_dp (which holds the RAM and divider).
//
// Usage:
// The input channel (item_valid/item_ready) carries one word per handshake.
// A word with mode 0 stores an output weight at row table_bucket, position
// table_index; mode 1 stores a bucket bias; mode 3 is dropped. These leave
// the block idle and ready for the next word. A mode 2 word streams one
// hidden element: both perspective values are clamped to 0..act_clip, squared
// and weighted by the bucket's stored weights. Each element occupies the block
// through the memory read and squaring, the two weight products and the
// accumulate, and no new word is taken until it is through.
// On the element flagged last_element the block finishes the evaluation: two
// serial divisions through one shared restoring divider, with the bias add and
// eval_scale product between them, and then loads the result register.
// The output channel (result_valid/result_ready) is backed by a result
// register. While a result waits, new elements are accepted and summed; only
// the next finished result stalls until the register drains.
// Reset clears the running sum, the element count and the output valid flag
// and restores the configuration defaults. The weight and bias stores are
// not cleared and read as unknown until written. The user writes configuration
// via cfg_wr_en/cfg_index/cfg_data only while idle; the block does not enforce it.
module screlu_output_layer_eval #(
    parameter int HIDDEN_SIZE = 1024,
    parameter int BUCKETS     = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [1:0]          mode,
    input  logic [2:0]          table_bucket,
    input  logic [10:0]         table_index,
    input  logic signed [15:0]  table_value,
    input  logic [5:0]          piece_count,
    input  logic                white_to_move,
    input  logic signed [15:0]  white_value,
    input  logic signed [15:0]  black_value,
    input  logic                last_element,
    output logic                result_valid,
    input  logic                result_ready,
    output logic signed [15:0]  evaluation,
    output logic [2:0]          used_bucket
);

    // Commands from the controller and status back from the datapath.
    solev_pkg::cmd_t    cmd;
    solev_pkg::status_t status;

    solev_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .mode         (mode),
        .result_ready (result_ready),
        .status       (status),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    solev_dp #(
        .HIDDEN_SIZE (HIDDEN_SIZE),
        .BUCKETS     (BUCKETS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .table_bucket  (table_bucket),
        .table_index   (table_index),
        .table_value   (table_value),
        .piece_count   (piece_count),
        .white_to_move (white_to_move),
        .white_value   (white_value),
        .black_value   (black_value),
        .last_element  (last_element),
        .cmd           (cmd),
        .status        (status),
        .evaluation    (evaluation),
        .used_bucket   (used_bucket)
    );

`ifndef SYNTHESIS
    // An accepted element keeps the block busy for the following cycle.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && (mode == solev_pkg::MODE_EVAL)) |=> !item_ready)
        else $error("input accepted while an element is still in work");

    // A finished result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid || result_ready))
        else $error("result register overwritten before it was taken");

    // Loading the result register always presents a word next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result_valid)
        else $error("loaded result not presented");
`endif

endmodule

>>> test/tb_screlu_output_layer_eval.sv
// Self-checking testbench for the clipped-square output layer evaluator.
// Needs solev_pkg and screlu_output_layer_eval with its submodules. A score
// tracker class predicts every result word and checks what the block returns.
module tb_screlu_output_layer_eval;
    import solev_pkg::*;

    // The block is built at its nominal size: 1024 hidden elements, 8 buckets.
    localparam int HIDDEN   = 1024;
    localparam int NBUCKETS = 8;

    // Mode 3 carries no operation; the block must drop such words.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // The element count stops climbing at the top of its 11-bit range.
    localparam int COUNT_TOP = 2047;

    // The quiet time allowed after the last result before registers change or
    // the run ends.
    localparam int SETTLE_CYCLES = 150;

    // Cycles with no handshake and no register write before the run is
    // declared hung.
    localparam int STALL_LIMIT = 3000;

    // One evaluation streams past the hidden size and past the count ceiling.
    localparam int LONG_ELEMS = 2060;

    // One input word, one field per port.
    typedef struct {
        logic [1:0]         mode;
        logic [2:0]         tbucket;
        logic [10:0]        tindex;
        logic signed [15:0] tvalue;
        logic [5:0]         pieces;
        logic               wtm;
        logic signed [15:0] wval;
        logic signed [15:0] bval;
        logic               last;
    } word_t;

    // One result word as the block should deliver it.
    typedef struct {
        logic signed [15:0] evaluation;
        logic [2:0]         bucket;
    } score_t;

    // The tracker keeps its own copy of the weight and bias tables, the running
    // sum, the element count and the registers. Every accepted input word is
    // applied to it; each finished evaluation queues one expected score.
    class score_tracker;
        logic signed [15:0] weight_mem [STORE_DEPTH];
        bit                 weight_set [STORE_DEPTH];
        logic signed [15:0] bias_mem [STORE_BUCKETS];
        bit                 bias_set [STORE_BUCKETS];
        logic [31:0]        acc;
        int                 count;
        longint             clip;
        longint             wscale;
        longint             escale;
        longint             limit;
        score_t             pending_scores [$];
        int                 errors;
        int                 checked;

        function new();
            acc     = '0;
            count   = 0;
            clip    = RST_ACT_CLIP;
            wscale  = RST_WEIGHT_SCALE;
            escale  = RST_EVAL_SCALE;
            limit   = RST_EVAL_LIMIT;
            errors  = 0;
            checked = 0;
        endfunction

        // Material bucket: piece counts below the minimum fold onto it, and
        // the result saturates at the last bucket.
        function int bucket_of(logic [5:0] pieces);
            int span;
            int pc;
            int b;
            span = (PIECE_SPAN + NBUCKETS - 1) / NBUCKETS;
            pc = pieces;
            if (pc < MIN_PIECES)
                pc = MIN_PIECES;
            b = (pc - MIN_PIECES) / span;
            if (b > NBUCKETS - 1)
                b = NBUCKETS - 1;
            if (b > STORE_BUCKETS - 1)
                b = STORE_BUCKETS - 1;
            return b;
        endfunction

        // Clamp to 0..act_clip and square.
        function longint activate(logic signed [15:0] x);
            longint c;
            c = x;
            if (c < 0)
                c = 0;
            if (c > clip)
                c = clip;
            return c * c;
        endfunction

        function void set_reg(logic [1:0] idx, logic [14:0] data);
            case (idx)
                CFG_ACT_CLIP:     clip = data;
                CFG_WEIGHT_SCALE: wscale = data;
                CFG_EVAL_SCALE:   escale = data[ESC_W-1:0];
                CFG_EVAL_LIMIT:   limit = data;
                default: ;
            endcase
        endfunction

        function void take_word(word_t w);
            int                 b;
            int                 a0;
            int                 a1;
            logic signed [15:0] stm;
            logic signed [15:0] nstm;
            longint             p0;
            longint             p1;
            longint             e;
            longint             qa;
            longint             qb;
            score_t             s;
            case (w.mode)
                MODE_WEIGHT:
                begin
                    weight_mem[{w.tbucket, w.tindex}] = w.tvalue;
                    weight_set[{w.tbucket, w.tindex}] = 1'b1;
                end
                MODE_BIAS:
                begin
                    bias_mem[w.tbucket] = w.tvalue;
                    bias_set[w.tbucket] = 1'b1;
                end
                MODE_EVAL:
                begin
                    b = bucket_of(w.pieces);
                    // Elements past the hidden size add nothing.
                    if (count < HIDDEN)
                    begin
                        a0 = count % ROW_WORDS;
                        a1 = (count + HIDDEN) % ROW_WORDS;
                        stm = w.wtm ? w.wval : w.bval;
                        nstm = w.wtm ? w.bval : w.wval;
                        p0 = activate(stm) * longint'(weight_mem[b * ROW_WORDS + a0]);
                        p1 = activate(nstm) * longint'(weight_mem[b * ROW_WORDS + a1]);
                        acc = acc + p0[31:0] + p1[31:0];
                    end
                    if (count < COUNT_TOP)
                        count++;
                    if (w.last)
                    begin
                        // A zero divisor register divides by one.
                        qa = (clip != 0) ? clip : 1;
                        qb = (wscale != 0) ? wscale : 1;
                        e = longint'($signed(acc)) / qa;
                        e = e + longint'(bias_mem[b]);
                        e = (e * escale) / (qa * qb);
                        if (e > limit)
                            e = limit;
                        if (e < -limit)
                            e = -limit;
                        s.evaluation = e[15:0];
                        s.bucket = b[2:0];
                        pending_scores.push_back(s);
                        acc = '0;
                        count = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_score(logic signed [15:0] ev, logic [2:0] ub);
            score_t s;
            if (pending_scores.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual eval %0d bucket %0d",
                         $time, ev, ub);
                return;
            end
            s = pending_scores.pop_front();
            checked++;
            if (ev !== s.evaluation)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: evaluation mismatch: expected %0d actual %0d",
                             $time, s.evaluation, ev);
            end
            if (ub !== s.bucket)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: used_bucket mismatch: expected %0d actual %0d",
                             $time, s.bucket, ub);
            end
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_wr_en     = 1'b0;
    logic [1:0]         cfg_index     = '0;
    logic [14:0]        cfg_data      = '0;
    logic               item_valid    = 1'b0;
    logic               item_ready;
    logic [1:0]         mode          = '0;
    logic [2:0]         table_bucket  = '0;
    logic [10:0]        table_index   = '0;
    logic signed [15:0] table_value   = '0;
    logic [5:0]         piece_count   = '0;
    logic               white_to_move = 1'b0;
    logic signed [15:0] white_value   = '0;
    logic signed [15:0] black_value   = '0;
    logic               last_element  = 1'b0;
    logic               result_valid;
    logic               result_ready  = 1'b0;
    logic signed [15:0] evaluation;
    logic [2:0]         used_bucket;

    score_tracker sb = new();

    // Words accepted that the block acts on; mode 3 words are not counted.
    int words_in     = 0;
    int settings_run = 1;
    int quiet_cycles = 0;

    // While a burst flag is set, that side runs with no idle cycles at all.
    bit in_burst  = 1'b0;
    bit out_burst = 1'b0;

    screlu_output_layer_eval #(
        .HIDDEN_SIZE (HIDDEN),
        .BUCKETS     (NBUCKETS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .mode          (mode),
        .table_bucket  (table_bucket),
        .table_index   (table_index),
        .table_value   (table_value),
        .piece_count   (piece_count),
        .white_to_move (white_to_move),
        .white_value   (white_value),
        .black_value   (black_value),
        .last_element  (last_element),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .evaluation    (evaluation),
        .used_bucket   (used_bucket)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle cycles before the next word on one side. Now and then the side
    // switches between random gaps and back-to-back traffic.
    function int draw_gap(inout bit burst);
        if ($urandom_range(0, 49) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // A word with every field random; callers overwrite what matters.
    function word_t junk_word();
        word_t w;
        w.mode    = 2'($urandom_range(0, 3));
        w.tbucket = 3'($urandom);
        w.tindex  = 11'($urandom);
        w.tvalue  = 16'($urandom);
        w.pieces  = 6'($urandom);
        w.wtm     = 1'($urandom);
        w.wval    = 16'($urandom);
        w.bval    = 16'($urandom);
        w.last    = 1'($urandom);
        return w;
    endfunction

    // Activation values: full range, near the clamp window, near zero, and
    // the edges of the window and of the 16-bit range.
    function logic signed [15:0] rand_activation();
        int v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2, 3:
            begin
                v = $urandom_range(0, int'(sb.clip) + 40);
                v = v - 20;
            end
            4:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    3: v = -1;
                    4: v = int'(sb.clip);
                    default: v = int'(sb.clip) + 1;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
        endcase
        return v[15:0];
    endfunction

    function logic signed [15:0] rand_weight();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'sh7FFF;
            1: v = 16'sh8000;
            2: v = 16'sh0000;
            3: v = 16'shFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Register values: the bounds of the range, raw 15-bit data, small values
    // and values anywhere in the range.
    function logic [14:0] pick_reg(int low, int high);
        int v;
        case ($urandom_range(0, 5))
            0: v = low;
            1: v = high;
            2: v = $urandom;
            3: v = $urandom_range(low, (high < 300) ? high : 300);
            default: v = $urandom_range(low, high);
        endcase
        return v[14:0];
    endfunction

    // Presents one word after its idle gap and holds it until accepted. Valid
    // stays high on return; the caller either sends the next word in the same
    // step or lowers valid before any pause.
    task automatic send_word(word_t w);
        int gap;
        gap = draw_gap(in_burst);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid    <= 1'b1;
        mode          <= w.mode;
        table_bucket  <= w.tbucket;
        table_index   <= w.tindex;
        table_value   <= w.tvalue;
        piece_count   <= w.pieces;
        white_to_move <= w.wtm;
        white_value   <= w.wval;
        black_value   <= w.bval;
        last_element  <= w.last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.take_word(w);
        if (w.mode != MODE_UNUSED)
            words_in++;
    endtask

    task automatic send_table(logic [1:0] m, int bucket, int index, logic signed [15:0] value);
        word_t w;
        w = junk_word();
        w.mode    = m;
        w.tbucket = 3'(bucket);
        w.tindex  = 11'(index);
        w.tvalue  = value;
        send_word(w);
    endtask

    // Sends one hidden element. The tables are never read where nothing was
    // stored: any weight this element reads, and the bias on a last element,
    // is first written with a random value if nothing is stored there yet.
    task automatic send_elem(int pieces, bit wtm, logic signed [15:0] wv,
                             logic signed [15:0] bv, bit last);
        word_t w;
        int    b;
        int    a0;
        int    a1;
        b  = sb.bucket_of(6'(pieces));
        a0 = sb.count % ROW_WORDS;
        a1 = (sb.count + HIDDEN) % ROW_WORDS;
        if (!sb.weight_set[b * ROW_WORDS + a0])
            send_table(MODE_WEIGHT, b, a0, rand_weight());
        if (!sb.weight_set[b * ROW_WORDS + a1])
            send_table(MODE_WEIGHT, b, a1, rand_weight());
        if (last && !sb.bias_set[b])
            send_table(MODE_BIAS, b, $urandom_range(0, 2047), rand_weight());
        w = junk_word();
        w.mode   = MODE_EVAL;
        w.pieces = 6'(pieces);
        w.wtm    = wtm;
        w.wval   = wv;
        w.bval   = bv;
        w.last   = last;
        send_word(w);
    endtask

    // The sender goes quiet until every expected score has come back, then
    // leaves the block time to finish whatever elements are still in flight.
    task automatic drain_and_settle();
        item_valid <= 1'b0;
        while (sb.pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [14:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // All four registers are rewritten back to back, only once the block has
    // gone idle. The write enable is lowered once, after the last one.
    task automatic load_regs(logic [14:0] c_clip, logic [14:0] c_wscale,
                             logic [14:0] c_escale, logic [14:0] c_limit);
        drain_and_settle();
        put_reg(CFG_ACT_CLIP, c_clip);
        put_reg(CFG_WEIGHT_SCALE, c_wscale);
        put_reg(CFG_EVAL_SCALE, c_escale);
        put_reg(CFG_EVAL_LIMIT, c_limit);
        cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    // Random traffic. Most of it is well-formed evaluations with random
    // content, mostly short; the rest is stray table writes, mode 3 words,
    // bucket changes inside an evaluation, and evaluations whose last flag
    // is dropped so they run on into the next one.
    task automatic random_block(int quota);
        int    target;
        int    pc;
        int    pck;
        int    len;
        int    r;
        int    k;
        bit    broken;
        word_t w;
        target = words_in + quota;
        while (words_in < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_table(MODE_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 2047),
                           rand_weight());
            else if (r < 11)
                send_table(MODE_BIAS, $urandom_range(0, 7), $urandom_range(0, 2047),
                           rand_weight());
            else if (r < 14)
            begin
                w = junk_word();
                w.mode = MODE_UNUSED;
                send_word(w);
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    pc = $urandom_range(0, 63);
                else
                    pc = $urandom_range(2, 32);
                r = $urandom_range(0, 19);
                if (r < 15)
                    len = $urandom_range(1, 6);
                else if (r < 19)
                    len = $urandom_range(7, 40);
                else
                    len = $urandom_range(41, 120);
                broken = ($urandom_range(0, 19) == 0);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_table(MODE_WEIGHT, $urandom_range(0, 7), $urandom_range(0, 2047),
                                   rand_weight());
                    if ($urandom_range(0, 9) == 0)
                        pck = $urandom_range(0, 63);
                    else
                        pck = pc;
                    send_elem(pck, $urandom_range(0, 1), rand_activation(), rand_activation(),
                              (k == len - 1) && !broken);
                end
            end
        end
        // Leave no evaluation open across a register change.
        if (sb.count != 0)
            send_elem($urandom_range(0, 63), $urandom_range(0, 1), rand_activation(),
                      rand_activation(), 1'b1);
    endtask

    // Result side: a random stall before each word, then ready is held until
    // a word is taken, which is compared with the oldest expected score.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(out_burst);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            sb.check_score(evaluation, used_bucket);
        end
    end

    // Watchdog: any handshake or register write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d scores still expected",
                     $time, STALL_LIMIT, sb.pending_scores.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        word_t w;
        int    k;
        int    pc;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset register values. Bucket 0 gets the
        // largest positive weight at element 0 and the most negative one at
        // its other-side position, plus the largest bias.
        send_table(MODE_WEIGHT, 0, 0, 16'sh7FFF);
        send_table(MODE_WEIGHT, 0, HIDDEN, 16'sh8000);
        send_table(MODE_BIAS, 0, 0, 16'sh7FFF);
        // One-element evaluation, white to move, white far above the clamp and
        // black far below zero: the sum nearly fills 32 bits and the score
        // hits the positive limit.
        send_elem(2, 1'b1, 16'sh7FFF, 16'sh8000, 1'b1);
        // Flip the weight to drive the score to the negative limit. A piece
        // count below the minimum still lands in bucket 0; black to move.
        send_table(MODE_WEIGHT, 0, 0, 16'sh8000);
        send_elem(1, 1'b0, -16'sd1, 16'sd300, 1'b1);
        // A mode 3 word must be dropped without effect.
        w = junk_word();
        w.mode = MODE_UNUSED;
        send_word(w);
        // Top bucket from a piece count beyond a full board, and the last
        // table position. Two elements, both of which fall in the top bucket.
        send_table(MODE_BIAS, 7, 2047, 16'sh8000);
        send_table(MODE_WEIGHT, 7, 2047, 16'sd1);
        send_elem(63, 1'b1, 16'sd255, 16'sd256, 1'b0);
        send_elem(32, 1'b0, 16'sd0, 16'sh8000, 1'b1);
        // Middle bucket with both values exactly at the clamp ceiling.
        send_elem(17, 1'b1, 16'sd255, 16'sd255, 1'b1);
        // Both values at the most negative code: only the bias remains.
        send_elem(0, 1'b0, 16'sh8000, 16'sh8000, 1'b1);
        // Smallest piece count above the minimum bucket boundary.
        send_elem(6, 1'b1, 16'sd1, -16'sd1, 1'b1);

        random_block(150);

        // Lowest register settings; a zero limit clamps every score to zero.
        load_regs(15'd1, 15'd1, 15'd1, 15'd0);
        random_block(150);

        // Highest register settings.
        load_regs(15'd32767, 15'd32767, 15'd4095, 15'd32767);
        random_block(120);

        // Zero divisor registers are taken as one.
        load_regs(15'd0, 15'd0, pick_reg(1, 4095), pick_reg(0, 32767));
        random_block(120);

        // One long evaluation: every weight of its bucket gets written along
        // the way, the count passes the hidden size, where elements stop
        // adding, and then sticks at its ceiling before the last element.
        load_regs(RST_ACT_CLIP, RST_WEIGHT_SCALE, 15'(RST_EVAL_SCALE), RST_EVAL_LIMIT);
        pc = $urandom_range(2, 32);
        for (k = 0; k < LONG_ELEMS; k++)
            send_elem(pc, $urandom_range(0, 1), rand_activation(), rand_activation(),
                      k == LONG_ELEMS - 1);

        repeat (5)
        begin
            load_regs(pick_reg(1, 32767), pick_reg(1, 32767), pick_reg(1, 4095),
                      pick_reg(0, 32767));
            random_block(130);
        end

        drain_and_settle();

        $display("Run covered %0d words over %0d register settings and checked %0d scores.",
                 words_in, settings_run, sb.checked);
        $display("It included one evaluation of %0d elements, past the count ceiling.",
                 LONG_ELEMS);
        if (sb.errors == 0 && sb.pending_scores.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
